// File: sv/lsbc_pkg.sv
// Shared constants, types and codes for the light sphere versus terrain box cull.
package lsbc_pkg;

    // Table size and coordinate format (8 fraction bits throughout)
    localparam int NUM_LIGHTS  = 32;
    localparam int COORD_WIDTH = 24;

    localparam int RADIUS_W = COORD_WIDTH - 1;
    localparam int SIZE_W   = 16;
    localparam int GRID_W   = 8;
    localparam int LEVEL_W  = 4;
    localparam int IDX_W    = 5;
    localparam int MASK_W   = 32;

    // grid * square_size, and square_size shifted by the widest level
    localparam int PROD_W = GRID_W + SIZE_W;
    localparam int EDGE_W = SIZE_W + (1 << LEVEL_W) - 1;
    // box bounds: origin plus product plus edge, signed, no overflow
    localparam int BOX_W  = ((COORD_WIDTH > EDGE_W) ? COORD_WIDTH : EDGE_W) + 3;

    // light table
    localparam int LIDX_W  = (NUM_LIGHTS > 1) ? $clog2(NUM_LIGHTS) : 1;
    localparam int CNT_W   = $clog2(NUM_LIGHTS + 1);
    localparam int LIGHT_W = 3 * COORD_WIDTH + RADIUS_W;

    // squared distances
    localparam int SQ_W  = 2 * RADIUS_W;
    localparam int SUM_W = SQ_W + 2;

    // item queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // input word layout, lowest bits first
    localparam int OFF_IDX   = 0;
    localparam int OFF_LX    = OFF_IDX + IDX_W;
    localparam int OFF_LY    = OFF_LX + COORD_WIDTH;
    localparam int OFF_LZ    = OFF_LY + COORD_WIDTH;
    localparam int OFF_LR    = OFF_LZ + COORD_WIDTH;
    localparam int OFF_GX    = OFF_LR + RADIUS_W;
    localparam int OFF_GY    = OFF_GX + GRID_W;
    localparam int OFF_LEVEL = OFF_GY + GRID_W;
    localparam int OFF_MINH  = OFF_LEVEL + LEVEL_W;
    localparam int OFF_MAXH  = OFF_MINH + COORD_WIDTH;
    localparam int OFF_MASK  = OFF_MAXH + COORD_WIDTH;
    localparam int IN_FIELDS_W = OFF_MASK + MASK_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = ((MASK_W + 7) / 8) * 8;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = (SIZE_W > COORD_WIDTH) ? SIZE_W : COORD_WIDTH;
    localparam logic [CFG_ADDR_W-1:0] CFG_SQUARE_SIZE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_X    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_Y    = 2'd2;
    localparam logic [SIZE_W-1:0]     SQUARE_SIZE_RST = 16'd256;

    // request kinds
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TEST = 1'b1;

    // one classified item as it travels from front to back
    typedef struct packed {
        logic                          kind;
        logic [IDX_W-1:0]              idx;
        logic signed [COORD_WIDTH-1:0] lx;
        logic signed [COORD_WIDTH-1:0] ly;
        logic signed [COORD_WIDTH-1:0] lz;
        logic [RADIUS_W-1:0]           lr;
        logic signed [BOX_W-1:0]       x0;
        logic signed [BOX_W-1:0]       x1;
        logic signed [BOX_W-1:0]       y0;
        logic signed [BOX_W-1:0]       y1;
        logic signed [COORD_WIDTH-1:0] z0;
        logic signed [COORD_WIDTH-1:0] z1;
        logic [MASK_W-1:0]             mask;
    } t_item;

endpackage

// File: sv/lsbc_ram.sv
// Generic single write port, single read port RAM with registered read.
module lsbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/lsbc_front.sv
// Front end: config registers, input word unpack, box bounds, push into the queue.
module lsbc_front
    import lsbc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // config writes
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    // input words
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic [IN_TUSER_W-1:0]  i_s_axis_tuser,
    // queue side
    output logic                   o_push,
    output t_item                  o_push_item,
    input  logic                   i_q_full
);

    typedef struct packed {
        logic                          kind;
        logic [IDX_W-1:0]              idx;
        logic signed [COORD_WIDTH-1:0] lx;
        logic signed [COORD_WIDTH-1:0] ly;
        logic signed [COORD_WIDTH-1:0] lz;
        logic [RADIUS_W-1:0]           lr;
        logic signed [BOX_W-1:0]       x0;
        logic signed [BOX_W-1:0]       y0;
        logic [EDGE_W-1:0]             edge_len;
        logic signed [COORD_WIDTH-1:0] z0;
        logic signed [COORD_WIDTH-1:0] z1;
        logic [MASK_W-1:0]             mask;
    } t_fstage;

    logic [SIZE_W-1:0]      r_square_size;
    logic [COORD_WIDTH-1:0] r_origin_x;
    logic [COORD_WIDTH-1:0] r_origin_y;

    logic    r_valid;
    t_fstage r_stage;
    t_fstage n_stage;

    logic              w_advance;
    logic [GRID_W-1:0] w_gx;
    logic [GRID_W-1:0] w_gy;
    logic [LEVEL_W-1:0] w_level;
    logic [PROD_W-1:0] w_prod_x;
    logic [PROD_W-1:0] w_prod_y;

    // config registers; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_square_size <= SQUARE_SIZE_RST;
            r_origin_x    <= '0;
            r_origin_y    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SQUARE_SIZE: r_square_size <= i_cfg_wdata[SIZE_W-1:0];
                CFG_ORIGIN_X:    r_origin_x    <= i_cfg_wdata[COORD_WIDTH-1:0];
                CFG_ORIGIN_Y:    r_origin_y    <= i_cfg_wdata[COORD_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // stage moves on when empty or when the queue takes its word
    assign w_advance       = !r_valid || !i_q_full;
    assign o_s_axis_tready = w_advance;

    // unpack and compute the low corner and edge of the box
    always_comb begin
        w_gx    = i_s_axis_tdata[OFF_GX +: GRID_W];
        w_gy    = i_s_axis_tdata[OFF_GY +: GRID_W];
        w_level = i_s_axis_tdata[OFF_LEVEL +: LEVEL_W];
        w_prod_x = {{SIZE_W{1'b0}}, w_gx} * {{GRID_W{1'b0}}, r_square_size};
        w_prod_y = {{SIZE_W{1'b0}}, w_gy} * {{GRID_W{1'b0}}, r_square_size};

        n_stage.kind = i_s_axis_tuser[0];
        n_stage.idx  = i_s_axis_tdata[OFF_IDX +: IDX_W];
        n_stage.lx   = i_s_axis_tdata[OFF_LX +: COORD_WIDTH];
        n_stage.ly   = i_s_axis_tdata[OFF_LY +: COORD_WIDTH];
        n_stage.lz   = i_s_axis_tdata[OFF_LZ +: COORD_WIDTH];
        n_stage.lr   = i_s_axis_tdata[OFF_LR +: RADIUS_W];
        n_stage.x0   = $signed({{(BOX_W-PROD_W){1'b0}}, w_prod_x})
                     + $signed({{(BOX_W-COORD_WIDTH){r_origin_x[COORD_WIDTH-1]}}, r_origin_x});
        n_stage.y0   = $signed({{(BOX_W-PROD_W){1'b0}}, w_prod_y})
                     + $signed({{(BOX_W-COORD_WIDTH){r_origin_y[COORD_WIDTH-1]}}, r_origin_y});
        n_stage.edge_len = {{(EDGE_W-SIZE_W){1'b0}}, r_square_size} << w_level;
        n_stage.z0   = i_s_axis_tdata[OFF_MINH +: COORD_WIDTH];
        n_stage.z1   = i_s_axis_tdata[OFF_MAXH +: COORD_WIDTH];
        n_stage.mask = i_s_axis_tdata[OFF_MASK +: MASK_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_advance) begin
            r_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && i_s_axis_tvalid) begin
            r_stage <= n_stage;
        end
    end

    // far corner added on the way into the queue
    assign o_push = r_valid && !i_q_full;

    always_comb begin
        o_push_item.kind = r_stage.kind;
        o_push_item.idx  = r_stage.idx;
        o_push_item.lx   = r_stage.lx;
        o_push_item.ly   = r_stage.ly;
        o_push_item.lz   = r_stage.lz;
        o_push_item.lr   = r_stage.lr;
        o_push_item.x0   = r_stage.x0;
        o_push_item.x1   = r_stage.x0 + $signed({{(BOX_W-EDGE_W){1'b0}}, r_stage.edge_len});
        o_push_item.y0   = r_stage.y0;
        o_push_item.y1   = r_stage.y0 + $signed({{(BOX_W-EDGE_W){1'b0}}, r_stage.edge_len});
        o_push_item.z0   = r_stage.z0;
        o_push_item.z1   = r_stage.z1;
        o_push_item.mask = r_stage.mask;
    end

endmodule

// File: sv/lsbc_queue.sv
// Short FIFO of classified items between front and back.
module lsbc_queue
    import lsbc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_empty
);

    t_item             r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_item;
        end
    end

    // pointers wrap at the depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

// File: sv/lsbc_back.sv
// Back end: light table writes, per-light distance pipeline, hit mask output register.
module lsbc_back
    import lsbc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // queue side
    input  t_item                  i_item,
    input  logic                   i_q_empty,
    output logic                   o_pop,
    // light table
    output logic                   o_ram_we,
    output logic [LIDX_W-1:0]      o_ram_waddr,
    output logic [LIGHT_W-1:0]     o_ram_wdata,
    output logic [LIDX_W-1:0]      o_ram_raddr,
    input  logic [LIGHT_W-1:0]     i_ram_rdata,
    // result words
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} t_state;

    t_state r_state;

    // box of the item under test
    logic signed [BOX_W-1:0] r_x0, r_x1, r_y0, r_y1, r_z0, r_z1;
    logic [MASK_W-1:0]       r_mask;
    logic [MASK_W-1:0]       r_hits;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_out_valid;
    logic [MASK_W-1:0]       r_out;

    // distance pipeline
    logic                r_v1, r_v2, r_v3;
    logic [LIDX_W-1:0]   r_i1, r_i2, r_i3;
    logic [RADIUS_W-1:0] r_dx, r_dy, r_dz, r_r2;
    logic                r_near2, r_near3;
    logic [SQ_W-1:0]     r_sq_x, r_sq_y, r_sq_z, r_sq_r;

    logic                    w_issue;
    logic                    w_last;
    logic                    w_hit;
    logic                    w_out_load;
    logic signed [BOX_W-1:0] w_px, w_py, w_pz;
    logic [BOX_W-1:0]        w_gx, w_gy, w_gz;
    logic [RADIUS_W-1:0]     w_r;
    logic [BOX_W-1:0]        w_rext;
    logic [SUM_W-1:0]        w_sum;

    // distance from p to [lo, hi]; lower bound checked first
    function automatic logic [BOX_W-1:0] f_gap(input logic signed [BOX_W-1:0] p,
                                              input logic signed [BOX_W-1:0] lo,
                                              input logic signed [BOX_W-1:0] hi);
        logic [BOX_W:0] d;
        begin
            d = '0;
            if (p < lo) begin
                d = {lo[BOX_W-1], lo} - {p[BOX_W-1], p};
            end else if (p > hi) begin
                d = {p[BOX_W-1], p} - {hi[BOX_W-1], hi};
            end
            return d[BOX_W-1:0];
        end
    endfunction

    // queue head is taken whenever the back is idle
    assign o_pop       = (r_state == ST_IDLE) && !i_q_empty;
    assign o_ram_we    = o_pop && (i_item.kind == REQ_LOAD)
                         && ({1'b0, i_item.idx} < (IDX_W + 1)'(NUM_LIGHTS));
    assign o_ram_waddr = i_item.idx[LIDX_W-1:0];
    assign o_ram_wdata = {i_item.lr, i_item.lz, i_item.ly, i_item.lx};

    // one table read per cycle during the scan
    assign w_issue     = (r_state == ST_SCAN) && (r_cnt < CNT_W'(NUM_LIGHTS));
    assign o_ram_raddr = r_cnt[LIDX_W-1:0];

    // finished mask moves to the output register once that slot is free
    assign w_out_load  = (r_state == ST_DONE) && (!r_out_valid || i_m_axis_tready);

    // gap per axis from the table word
    always_comb begin
        w_px = $signed({{(BOX_W-COORD_WIDTH){i_ram_rdata[COORD_WIDTH-1]}},
                        i_ram_rdata[COORD_WIDTH-1:0]});
        w_py = $signed({{(BOX_W-COORD_WIDTH){i_ram_rdata[2*COORD_WIDTH-1]}},
                        i_ram_rdata[COORD_WIDTH +: COORD_WIDTH]});
        w_pz = $signed({{(BOX_W-COORD_WIDTH){i_ram_rdata[3*COORD_WIDTH-1]}},
                        i_ram_rdata[2*COORD_WIDTH +: COORD_WIDTH]});
        w_r    = i_ram_rdata[3*COORD_WIDTH +: RADIUS_W];
        w_rext = {{(BOX_W-RADIUS_W){1'b0}}, w_r};
        w_gx   = f_gap(w_px, r_x0, r_x1);
        w_gy   = f_gap(w_py, r_y0, r_y1);
        w_gz   = f_gap(w_pz, r_z0, r_z1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= w_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // gaps, then squares; a gap not below the radius is a miss on its own
    always_ff @(posedge i_clk) begin
        r_i1    <= r_cnt[LIDX_W-1:0];
        r_i2    <= r_i1;
        r_dx    <= w_gx[RADIUS_W-1:0];
        r_dy    <= w_gy[RADIUS_W-1:0];
        r_dz    <= w_gz[RADIUS_W-1:0];
        r_r2    <= w_r;
        r_near2 <= (w_gx < w_rext) && (w_gy < w_rext) && (w_gz < w_rext);
        r_i3    <= r_i2;
        r_near3 <= r_near2;
        r_sq_x  <= r_dx * r_dx;
        r_sq_y  <= r_dy * r_dy;
        r_sq_z  <= r_dz * r_dz;
        r_sq_r  <= r_r2 * r_r2;
    end

    // sum and compare at the end of the pipe
    always_comb begin
        w_sum  = SUM_W'(r_sq_x) + SUM_W'(r_sq_y) + SUM_W'(r_sq_z);
        w_hit  = r_near3 && (w_sum < SUM_W'(r_sq_r)) && r_mask[r_i3];
        w_last = r_v3 && (r_i3 == LIDX_W'(NUM_LIGHTS - 1));
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_pop && (i_item.kind == REQ_TEST)) begin
                        r_x0    <= i_item.x0;
                        r_x1    <= i_item.x1;
                        r_y0    <= i_item.y0;
                        r_y1    <= i_item.y1;
                        r_z0    <= $signed({{(BOX_W-COORD_WIDTH){i_item.z0[COORD_WIDTH-1]}},
                                            i_item.z0});
                        r_z1    <= $signed({{(BOX_W-COORD_WIDTH){i_item.z1[COORD_WIDTH-1]}},
                                            i_item.z1});
                        r_mask  <= i_item.mask;
                        r_hits  <= '0;
                        r_cnt   <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (w_issue) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (r_v3 && w_hit) begin
                        r_hits[r_i3] <= 1'b1;
                    end
                    if (w_last) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_load) begin
                        r_out   <= r_hits;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'(r_out);

endmodule

// File: sv/light_sphere_box_cull.sv
// Top level: light sphere versus terrain box cull, front, queue, back and light table.
// Load word: registered in the front stage, held in the queue, then written to the table by the back.
// Test word: front stage, queue, then a scan through the table and the distance pipeline, then the output register.
// Tests are handled one at a time: the single distance pipeline visits every table
// entry in turn, one table read per cycle, while the front and queue can hold further words.
// Synchronous active-low reset clears control state and config; table contents stay.
module light_sphere_box_cull
    import lsbc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // config writes
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    // input words
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // light_index, light_x, light_y, light_z, light_radius, grid_x, grid_y, level,
    // min_height, max_height, light_mask
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // req_type
    input  logic [IN_TUSER_W-1:0]  i_s_axis_tuser,
    // result words
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // hit_mask
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    logic               w_push;
    t_item              w_push_item;
    logic               w_q_full;
    logic               w_pop;
    t_item              w_head;
    logic               w_q_empty;
    logic               w_ram_we;
    logic [LIDX_W-1:0]  w_ram_waddr;
    logic [LIGHT_W-1:0] w_ram_wdata;
    logic [LIDX_W-1:0]  w_ram_raddr;
    logic [LIGHT_W-1:0] w_ram_rdata;

    lsbc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_push          (w_push),
        .o_push_item     (w_push_item),
        .i_q_full        (w_q_full)
    );

    lsbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_item  (w_head),
        .o_empty (w_q_empty)
    );

    lsbc_ram #(
        .WIDTH (LIGHT_W),
        .DEPTH (NUM_LIGHTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    lsbc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (w_head),
        .i_q_empty       (w_q_empty),
        .o_pop           (w_pop),
        .o_ram_we        (w_ram_we),
        .o_ram_waddr     (w_ram_waddr),
        .o_ram_wdata     (w_ram_wdata),
        .o_ram_raddr     (w_ram_raddr),
        .i_ram_rdata     (w_ram_rdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

// File: sv/lsbc_checker.sv
// Port-level checks for the cull block, bound to the top level.
module lsbc_checker
    import lsbc_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_s_axis_tready,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    // a waiting result stays up until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result word dropped before it was taken");

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // reset empties the front stage, so input is ready right after
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready)
        else $error("input not ready after reset");

    // a waiting result word keeps its data until taken
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result word changed while waiting");

endmodule

bind light_sphere_box_cull lsbc_checker u_lsbc_checker (.*);
